// ===== sv/crfp_pkg.sv =====
// package for the camera reply frame parser
// holds the phase and event codes, header characters and the result item type
// no dependencies

package crfp_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxLenW = 24;
  localparam int unsigned LenW    = 32;
  localparam int unsigned OffW    = 24;
  localparam int unsigned KindW   = 3;

  // reset value of the maximum image length register (128 KiB)
  localparam logic [MaxLenW-1:0] MaxLenReset = MaxLenW'(128 * 1024);

  // header characters
  localparam logic [ByteW-1:0] ChA = 8'h41;
  localparam logic [ByteW-1:0] ChC = 8'h43;
  localparam logic [ByteW-1:0] ChK = 8'h4B;
  localparam logic [ByteW-1:0] ChR = 8'h52;
  localparam logic [ByteW-1:0] ChE = 8'h45;
  localparam logic [ByteW-1:0] ChS = 8'h53;
  localparam logic [ByteW-1:0] ChI = 8'h49;
  localparam logic [ByteW-1:0] ChM = 8'h4D;
  localparam logic [ByteW-1:0] ChG = 8'h47;
  localparam logic [ByteW-1:0] ChN = 8'h4E;
  localparam logic [ByteW-1:0] ChD = 8'h44;

  // receive phase
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_ACK_ST  = 3'd3,
    PH_RES_ST  = 3'd4,
    PH_RES_VAL = 3'd5,
    PH_LEN     = 3'd6,
    PH_DATA    = 3'd7
  } phase_e;

  // event kinds of a result item
  typedef enum logic [KindW-1:0] {
    EV_BURST_ACK  = 3'd0,
    EV_RES_ACK    = 3'd1,
    EV_IMG_START  = 3'd2,
    EV_IMG_BYTE   = 3'd3,
    EV_END        = 3'd4,
    EV_SYNC_LOST  = 3'd5,
    EV_LEN_REJECT = 3'd6
  } event_kind_e;

  // one result item
  typedef struct packed {
    event_kind_e      kind;
    logic [ByteW-1:0] status;
    logic [ByteW-1:0] payload;
    logic [LenW-1:0]  length;
    logic [OffW-1:0]  offset;
    logic             last;
  } result_t;

endpackage

// ===== sv/camera_reply_frame_parser.sv =====
// camera reply frame parser top level
// deframes ACK, RES, IMG and END replies from a received byte stream
// depends on crfp_pkg

// Usage
// - input channel: one received byte per item on rx_byte_i, in_valid_i and
//   in_stall_o; an item is taken when in_valid_i is high and in_stall_o low
// - output channel: zero or one result item per input item, out_valid_o and
//   out_stall_i; taken when out_valid_o is high and out_stall_i low
// - config channel: cfg_valid_i / cfg_ready_o write max_image_len, always
//   ready; write only while the parser is idle
// - each result is registered, in the result register or the skid entry
// - throughput: one byte per cycle while in_stall_o is low; the phase update
//   and result build are a single logic pass from phase to result register
// - a result register plus one skid entry lets the parser keep taking bytes
//   after the receiver stalls until one more result item is waiting;
//   in_stall_o rises only when the skid entry is full
// - reset: phase returns to waiting for a first header byte, both result
//   entries empty, max_image_len back to 131072

module camera_reply_frame_parser
  import crfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [MaxLenW-1:0] cfg_wdata_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [KindW-1:0]   event_kind_o,
  output logic [ByteW-1:0]   reply_status_o,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic [LenW-1:0]    announced_length_o,
  output logic [OffW-1:0]    byte_offset_o,
  output logic               last_byte_o
);

  // parser state
  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   hdr_first_q, hdr_first_d;
  logic [ByteW-1:0]   hdr_second_q, hdr_second_d;
  logic [LenW-1:0]    len_acc_q, len_acc_d;
  logic [1:0]         len_cnt_q, len_cnt_d;
  logic [OffW-1:0]    taken_q, taken_d;
  logic [ByteW-1:0]   held_status_q, held_status_d;
  logic [MaxLenW-1:0] max_len_q;

  // result storage
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_q, skid_d;

  logic    in_acc;
  logic    out_take;
  logic    res_valid;
  result_t res;

  // combinational helpers
  logic [LenW-1:0] len_full;
  logic [OffW:0]   off_next;
  logic            data_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;

  // length as it stands after taking this byte
  always_comb begin
    len_full = len_acc_q | (LenW'(rx_byte_i) << {len_cnt_q, 3'b000});
  end

  assign off_next  = {1'b0, taken_q} + (OffW+1)'(1);
  assign data_last = LenW'(off_next) >= len_acc_q;

  // next phase and parser state
  always_comb begin
    phase_d       = phase_q;
    hdr_first_d   = hdr_first_q;
    hdr_second_d  = hdr_second_q;
    len_acc_d     = len_acc_q;
    len_cnt_d     = len_cnt_q;
    taken_d       = taken_q;
    held_status_d = held_status_q;
    if (in_acc) begin
      unique case (phase_q)
        PH_HDR0: begin
          hdr_first_d = rx_byte_i;
          phase_d     = PH_HDR1;
        end
        PH_HDR1: begin
          hdr_second_d = rx_byte_i;
          phase_d      = PH_HDR2;
        end
        PH_HDR2: begin
          if (hdr_first_q == ChA && hdr_second_q == ChC && rx_byte_i == ChK) begin
            phase_d = PH_ACK_ST;
          end else if (hdr_first_q == ChR && hdr_second_q == ChE && rx_byte_i == ChS) begin
            phase_d = PH_RES_ST;
          end else if (hdr_first_q == ChI && hdr_second_q == ChM && rx_byte_i == ChG) begin
            len_acc_d = '0;
            len_cnt_d = '0;
            phase_d   = PH_LEN;
          end else begin
            len_cnt_d = '0;
            phase_d   = PH_HDR0;
          end
        end
        PH_ACK_ST: phase_d = PH_HDR0;
        PH_RES_ST: begin
          held_status_d = rx_byte_i;
          phase_d       = PH_RES_VAL;
        end
        PH_RES_VAL: phase_d = PH_HDR0;
        PH_LEN: begin
          len_acc_d = len_full;
          if (len_cnt_q != 2'd3) begin
            len_cnt_d = len_cnt_q + 2'd1;
          end else begin
            len_cnt_d = '0;
            if (len_full == '0 || len_full > LenW'(max_len_q)) begin
              phase_d = PH_HDR0;
            end else begin
              taken_d = '0;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (data_last) begin
            taken_d = '0;
            phase_d = PH_HDR0;
          end else begin
            taken_d = off_next[OffW-1:0];
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end
  end

  // result item built from the current byte
  always_comb begin
    res_valid   = 1'b0;
    res.kind    = EV_SYNC_LOST;
    res.status  = '0;
    res.payload = '0;
    res.length  = '0;
    res.offset  = '0;
    res.last    = 1'b0;
    unique case (phase_q)
      PH_HDR2: begin
        if (hdr_first_q == ChE && hdr_second_q == ChN && rx_byte_i == ChD) begin
          res_valid = 1'b1;
          res.kind  = EV_END;
        end else if (!(hdr_first_q == ChA && hdr_second_q == ChC && rx_byte_i == ChK) &&
                     !(hdr_first_q == ChR && hdr_second_q == ChE && rx_byte_i == ChS) &&
                     !(hdr_first_q == ChI && hdr_second_q == ChM && rx_byte_i == ChG)) begin
          res_valid = 1'b1;
          res.kind  = EV_SYNC_LOST;
        end
      end
      PH_ACK_ST: begin
        res_valid  = 1'b1;
        res.kind   = EV_BURST_ACK;
        res.status = rx_byte_i;
      end
      PH_RES_VAL: begin
        res_valid   = 1'b1;
        res.kind    = EV_RES_ACK;
        res.status  = held_status_q;
        res.payload = rx_byte_i;
      end
      PH_LEN: begin
        if (len_cnt_q == 2'd3) begin
          res_valid  = 1'b1;
          res.length = len_full;
          if (len_full == '0 || len_full > LenW'(max_len_q)) begin
            res.kind = EV_LEN_REJECT;
          end else begin
            res.kind = EV_IMG_START;
          end
        end
      end
      PH_DATA: begin
        res_valid   = 1'b1;
        res.kind    = EV_IMG_BYTE;
        res.payload = rx_byte_i;
        res.offset  = taken_q;
        res.last    = data_last;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // result register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && out_take) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end else if (in_acc && res_valid) begin
      if (!out_valid_q || out_take) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HDR0;
      hdr_first_q   <= '0;
      hdr_second_q  <= '0;
      len_acc_q     <= '0;
      len_cnt_q     <= '0;
      taken_q       <= '0;
      held_status_q <= '0;
      max_len_q     <= MaxLenReset;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_first_q   <= hdr_first_d;
      hdr_second_q  <= hdr_second_d;
      len_acc_q     <= len_acc_d;
      len_cnt_q     <= len_cnt_d;
      taken_q       <= taken_d;
      held_status_q <= held_status_d;
      out_valid_q   <= out_valid_d;
      skid_valid_q  <= skid_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = out_q.kind;
  assign reply_status_o     = out_q.status;
  assign payload_byte_o     = out_q.payload;
  assign announced_length_o = out_q.length;
  assign byte_offset_o      = out_q.offset;
  assign last_byte_o        = out_q.last;

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds an item while the result register is empty");

  // an image in progress never runs past its length
  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (LenW'(taken_q) < len_acc_q))
    else $error("image byte count reached the announced length");

  // length byte count is only nonzero while gathering the length
  a_len_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_LEN) |-> (len_cnt_q == 2'd0))
    else $error("length byte count left nonzero outside length gathering");

  // a stalled result is not replaced
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

// ===== test/tb_camera_reply_frame_parser.sv =====
// testbench for the camera reply frame parser
// drives byte streams of ACK, RES, END and IMG replies plus broken headers and noise,
// predicts each event in its own parser model and checks it; depends on crfp_pkg

module tb_camera_reply_frame_parser;
  import crfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // reply headers as three characters, first one on top
  localparam logic [23:0] HdrAck = {ChA, ChC, ChK};
  localparam logic [23:0] HdrRes = {ChR, ChE, ChS};
  localparam logic [23:0] HdrImg = {ChI, ChM, ChG};
  localparam logic [23:0] HdrEnd = {ChE, ChN, ChD};
  localparam result_t     NoRes  = '0;
  localparam int          PhaseBytes = 270;

  // one row of the directed table
  typedef struct packed {
    logic [ByteW-1:0]   rx;
    logic               typed;
    result_t            res;
    logic               max_wr;
    logic [MaxLenW-1:0] max_val;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [MaxLenW-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [KindW-1:0]   event_kind_o;
  logic [ByteW-1:0]   reply_status_o;
  logic [ByteW-1:0]   payload_byte_o;
  logic [LenW-1:0]    announced_length_o;
  logic [OffW-1:0]    byte_offset_o;
  logic               last_byte_o;

  // parser model state
  phase_e             parse_phase;
  logic [ByteW-1:0]   hdr_first, hdr_second, res_status;
  logic [LenW-1:0]    img_len;
  logic [1:0]         len_bytes;
  logic [OffW-1:0]    img_pos;
  logic [MaxLenW-1:0] max_len_cfg;

  result_t pending_events [$];
  row_t    dir_rows [$];
  result_t seen_event;
  int      send_idle_pct = 31;
  int      recv_idle_pct = 64;
  int      rcv_cycles = 0;
  int      hold_left = 0;
  int      bytes_sent = 0;
  int      errors = 0;
  int      kind_count [8];

  camera_reply_frame_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_kind_o       (event_kind_o),
    .reply_status_o     (reply_status_o),
    .payload_byte_o     (payload_byte_o),
    .announced_length_o (announced_length_o),
    .byte_offset_o      (byte_offset_o),
    .last_byte_o        (last_byte_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // advance the parser model by one byte, returns 1 when an event comes out
  function automatic bit parse_rx_byte(input logic [ByteW-1:0] b, output result_t ev);
    bit             got;
    logic [OffW-1:0] off;
    logic           fin;
    got = 1'b0;
    ev  = '0;
    case (parse_phase)
      PH_HDR0: begin
        hdr_first   = b;
        parse_phase = PH_HDR1;
      end
      PH_HDR1: begin
        hdr_second  = b;
        parse_phase = PH_HDR2;
      end
      PH_HDR2: begin
        if ({hdr_first, hdr_second, b} == HdrAck) begin
          parse_phase = PH_ACK_ST;
        end else if ({hdr_first, hdr_second, b} == HdrRes) begin
          parse_phase = PH_RES_ST;
        end else if ({hdr_first, hdr_second, b} == HdrImg) begin
          img_len     = '0;
          len_bytes   = '0;
          parse_phase = PH_LEN;
        end else begin
          // unknown header drops all three bytes, no sliding search
          parse_phase = PH_HDR0;
          len_bytes   = '0;
          got         = 1'b1;
          ev.kind     = ({hdr_first, hdr_second, b} == HdrEnd) ? EV_END : EV_SYNC_LOST;
        end
      end
      PH_ACK_ST: begin
        parse_phase = PH_HDR0;
        got         = 1'b1;
        ev.kind     = EV_BURST_ACK;
        ev.status   = b;
      end
      PH_RES_ST: begin
        res_status  = b;
        parse_phase = PH_RES_VAL;
      end
      PH_RES_VAL: begin
        parse_phase = PH_HDR0;
        got         = 1'b1;
        ev.kind     = EV_RES_ACK;
        ev.status   = res_status;
        ev.payload  = b;
      end
      PH_LEN: begin
        // little-endian length, checked against the max on the fourth byte
        img_len = img_len | ({24'd0, b} << (8 * len_bytes));
        if (len_bytes != 2'd3) begin
          len_bytes = len_bytes + 2'd1;
        end else begin
          len_bytes = '0;
          got       = 1'b1;
          ev.length = img_len;
          if (img_len == '0 || img_len > {8'd0, max_len_cfg}) begin
            parse_phase = PH_HDR0;
            ev.kind     = EV_LEN_REJECT;
          end else begin
            img_pos     = '0;
            parse_phase = PH_DATA;
            ev.kind     = EV_IMG_START;
          end
        end
      end
      default: begin
        off        = img_pos;
        fin        = ({8'd0, off} + 32'd1) >= img_len;
        got        = 1'b1;
        ev.kind    = EV_IMG_BYTE;
        ev.payload = b;
        ev.offset  = off;
        ev.last    = fin;
        if (fin) begin
          parse_phase = PH_HDR0;
          img_pos     = '0;
        end else begin
          img_pos = off + 24'd1;
        end
      end
    endcase
    return got;
  endfunction

  function automatic result_t res_of(input event_kind_e k, input logic [ByteW-1:0] st,
                                     input logic [ByteW-1:0] pay, input logic [LenW-1:0] len);
    result_t r;
    r         = '0;
    r.kind    = k;
    r.status  = st;
    r.payload = pay;
    r.length  = len;
    return r;
  endfunction

  task automatic add_row(input logic [ByteW-1:0] rx, input logic typed, input result_t res,
                         input logic max_wr, input logic [MaxLenW-1:0] max_val);
    row_t r;
    r.rx      = rx;
    r.typed   = typed;
    r.res     = res;
    r.max_wr  = max_wr;
    r.max_val = max_val;
    dir_rows.push_back(r);
  endtask

  // offer one byte with random gaps, then predict once it is taken
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input result_t typed_res);
    result_t ev;
    bit      got;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    got = parse_rx_byte(b, ev);
    if (typed) pending_events.push_back(typed_res);
    else if (got) pending_events.push_back(ev);
    bytes_sent++;
  endtask

  task automatic send_rx(input logic [ByteW-1:0] b);
    send_byte(b, 1'b0, NoRes);
  endtask

  task automatic send_hdr(input logic [23:0] h);
    send_rx(h[23:16]);
    send_rx(h[15:8]);
    send_rx(h[7:0]);
  endtask

  // stop offering and let every expected event come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [MaxLenW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one random reply: mostly well formed, some broken headers and noise
  task automatic send_reply();
    int              pick;
    int              hi;
    int              pos;
    logic [LenW-1:0] len;
    logic [23:0]     h;
    logic [ByteW-1:0] alt;
    pick = $urandom_range(99);
    if (pick < 14) begin
      send_hdr(HdrAck);
      send_rx(8'($urandom));
    end else if (pick < 28) begin
      send_hdr(HdrRes);
      send_rx(8'($urandom));
      send_rx(8'($urandom));
    end else if (pick < 38) begin
      send_hdr(HdrEnd);
    end else if (pick < 75) begin
      // image: lengths mostly accepted, small or at the max, the rest rejected
      hi   = (max_len_cfg < 24) ? int'(max_len_cfg) : 24;
      pick = $urandom_range(99);
      if (pick < 62) len = $urandom_range(hi, 1);
      else if (pick < 70) len = (max_len_cfg <= 600) ? {8'd0, max_len_cfg} : $urandom_range(hi, 1);
      else if (pick < 76) len = '0;
      else if (pick < 82) len = '1;
      else if (pick < 90) len = {8'd0, max_len_cfg} + 32'd1;
      else len = $urandom | 32'h0100_0000;
      send_hdr(HdrImg);
      send_rx(len[7:0]);
      send_rx(len[15:8]);
      send_rx(len[23:16]);
      send_rx(len[31:24]);
      if (len != '0 && len <= {8'd0, max_len_cfg}) begin
        for (int i = 0; i < int'(len); i++) send_rx(8'($urandom));
      end
    end else if (pick < 88) begin
      // one character of a valid header corrupted; headers differ in every position
      case ($urandom_range(3))
        0: h = HdrAck;
        1: h = HdrRes;
        2: h = HdrImg;
        default: h = HdrEnd;
      endcase
      pos = $urandom_range(2);
      do alt = 8'($urandom); while (alt == h[8*pos +: 8]);
      h[8*pos +: 8] = alt;
      send_hdr(h);
    end else begin
      // a byte or two of noise, then zeros until the header realigns
      repeat ($urandom_range(2, 1)) send_rx(8'($urandom));
      while (parse_phase != PH_HDR0) send_rx(8'h00);
    end
  endtask

  // receiver stalls, with a long hold now and then to back up the input
  always @(negedge clk_i) begin
    rcv_cycles++;
    if (rcv_cycles % 4000 == 400) hold_left = 60;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic cmp_field(input string what, input logic [31:0] want_v,
                           input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endtask

  // check each taken event against the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: event kind %0d with nothing expected", $time, event_kind_o);
      end else begin
        seen_event = pending_events.pop_front();
        kind_count[event_kind_o]++;
        cmp_field("event_kind", 32'(seen_event.kind), 32'(event_kind_o));
        cmp_field("reply_status", 32'(seen_event.status), 32'(reply_status_o));
        cmp_field("payload_byte", 32'(seen_event.payload), 32'(payload_byte_o));
        cmp_field("announced_length", seen_event.length, announced_length_o);
        cmp_field("byte_offset", 32'(seen_event.offset), 32'(byte_offset_o));
        cmp_field("last_byte", 32'(seen_event.last), 32'(last_byte_o));
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [MaxLenW-1:0] max_steps [6];
    int                 phase_start;
    parse_phase = PH_HDR0;
    hdr_first   = '0;
    hdr_second  = '0;
    res_status  = '0;
    img_len     = '0;
    len_bytes   = '0;
    img_pos     = '0;
    max_len_cfg = MaxLenReset;
    foreach (kind_count[k]) kind_count[k] = 0;

    // directed replies: status extremes, every header, sync loss, length extremes
    add_row(ChA, 1'b0, NoRes, 1'b0, '0);
    add_row(ChC, 1'b0, NoRes, 1'b0, '0);
    add_row(ChK, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b1, res_of(EV_BURST_ACK, 8'hFF, 8'h00, 32'h0), 1'b0, '0);
    add_row(ChR, 1'b0, NoRes, 1'b0, '0);
    add_row(ChE, 1'b0, NoRes, 1'b0, '0);
    add_row(ChS, 1'b0, NoRes, 1'b0, '0);
    add_row(8'h00, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b1, res_of(EV_RES_ACK, 8'h00, 8'hFF, 32'h0), 1'b0, '0);
    add_row(ChE, 1'b0, NoRes, 1'b0, '0);
    add_row(ChN, 1'b0, NoRes, 1'b0, '0);
    add_row(ChD, 1'b1, res_of(EV_END, 8'h00, 8'h00, 32'h0), 1'b0, '0);
    // partial match still loses sync, next byte starts a fresh header
    add_row(ChA, 1'b0, NoRes, 1'b0, '0);
    add_row(ChC, 1'b0, NoRes, 1'b0, '0);
    add_row(ChD, 1'b1, res_of(EV_SYNC_LOST, 8'h00, 8'h00, 32'h0), 1'b0, '0);
    add_row(ChI, 1'b0, NoRes, 1'b0, '0);
    add_row(ChM, 1'b0, NoRes, 1'b0, '0);
    add_row(ChG, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b0, NoRes, 1'b0, '0);
    add_row(8'hFF, 1'b1, res_of(EV_LEN_REJECT, 8'h00, 8'h00, 32'hFFFF_FFFF), 1'b0, '0);
    // two-byte image, max lowered to one mid-image keeps the accepted length
    add_row(ChI, 1'b0, NoRes, 1'b0, '0);
    add_row(ChM, 1'b0, NoRes, 1'b0, '0);
    add_row(ChG, 1'b0, NoRes, 1'b0, '0);
    add_row(8'h02, 1'b0, NoRes, 1'b0, '0);
    add_row(8'h00, 1'b0, NoRes, 1'b0, '0);
    add_row(8'h00, 1'b0, NoRes, 1'b0, '0);
    add_row(8'h00, 1'b1, res_of(EV_IMG_START, 8'h00, 8'h00, 32'h2), 1'b0, '0);
    add_row(8'h00, 1'b0, NoRes, 1'b1, 24'd1);
    add_row(8'hFF, 1'b0, NoRes, 1'b0, '0);

    max_steps[0] = MaxLenReset;
    max_steps[1] = 24'd1;
    max_steps[2] = 24'hFF_FFFF;
    max_steps[3] = 24'($urandom_range(40, 2));
    max_steps[4] = 24'($urandom_range(600, 41));
    max_steps[5] = MaxLenReset;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].max_wr) begin
        settle();
        write_max_len(dir_rows[i].max_val);
      end
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);
    end

    // random replies under each max setting and idle pattern
    for (int p = 0; p < 6; p++) begin
      settle();
      write_max_len(max_steps[p]);
      if (p < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 64;
      end else if (p < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_reply();
    end
    settle();

    $display("covered %0d bytes under six max length settings and three idle patterns",
             bytes_sent);
    $display("events: %0d acks, %0d res acks, %0d starts, %0d data, %0d ends, %0d syncs, %0d rejects",
             kind_count[EV_BURST_ACK], kind_count[EV_RES_ACK], kind_count[EV_IMG_START],
             kind_count[EV_IMG_BYTE], kind_count[EV_END], kind_count[EV_SYNC_LOST],
             kind_count[EV_LEN_REJECT]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
